// ----- hdl/fsla_pkg.sv -----
package fsla_pkg;

  // Link store geometry
  localparam int unsigned MaxSlots = 1024;
  localparam int unsigned SlotW    = $clog2(MaxSlots);
  localparam int unsigned LinkW    = $clog2(MaxSlots + 1);

  typedef logic [LinkW-1:0] link_t;
  localparam link_t NoneLink = link_t'(MaxSlots);

  // Operation codes carried in the input tuser
  typedef enum logic [1:0] {
    FnAlloc   = 2'd0,
    FnRelease = 2'd1,
    FnRebuild = 2'd2,
    FnNop     = 2'd3
  } func_e;

  // Result status codes
  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StEmpty = 2'd1,
    StWrong = 2'd2,
    StSmall = 2'd3
  } status_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CfgHeader = 2'd0,
    CfgSlot   = 2'd1,
    CfgPool   = 2'd2,
    CfgIdent  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] header_bytes;
    logic [20:0] slot_bytes;
    logic [23:0] pool_bytes;
    logic [7:0]  pool_ident;
  } cfg_t;

  // Result item, status in the lowest bits
  typedef struct packed {
    logic             pool_empty;
    logic [10:0]      slot_total;
    logic [23:0]      byte_offset;
    logic [SlotW-1:0] granted_slot;
    status_e          status;
  } res_t;

  // Link memory access
  typedef struct packed {
    logic             rd_en;
    logic [SlotW-1:0] rd_addr;
    logic             wr_en;
    logic [SlotW-1:0] wr_addr;
    link_t            wr_data;
  } mem_req_t;

endpackage

// ----- hdl/fixed_slot_free_list_allocator.sv -----
// Flow: an allocate on a non-empty list reads the head's link with the request and loads its
//   result from SAlloc; other results load from SResp, after SBuild for a rebuild that fits.
// SBuild writes one link per slot. A new request is taken only in SIdle, once the last result
//   is in the output register; loading waits while that register is full and not being taken.
// The next input is taken while a result still waits in the output register.
// Reset: control and config registers return to defaults, free list empty, slot count zero, link
//   memory not cleared and needs no clearing pass, as entries are only read after being written.
module fixed_slot_free_list_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration writes
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i,
  // Request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // slot_index[9:0], owner_pool[17:10], zero fill
  input  logic [1:0]  s_axis_tuser,   // func[1:0]
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // status, granted_slot, byte_offset, slot_total, pool_empty
);

  fsla_pkg::cfg_t     cfg_q;
  fsla_pkg::res_t     ctrl_res;
  fsla_pkg::res_t     out_q;
  fsla_pkg::mem_req_t mem_req;
  fsla_pkg::link_t    rd_data;
  logic               out_valid_q;
  logic               out_free;
  logic               out_push;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_bytes <= 16'd64;
      cfg_q.slot_bytes   <= 21'd64;
      cfg_q.pool_bytes   <= '0;
      cfg_q.pool_ident   <= '0;
    end else if (cfg_we_i) begin
      unique case (fsla_pkg::cfg_idx_e'(cfg_idx_i))
        fsla_pkg::CfgHeader: cfg_q.header_bytes <= cfg_data_i[15:0];
        fsla_pkg::CfgSlot:   cfg_q.slot_bytes   <= cfg_data_i[20:0];
        fsla_pkg::CfgPool:   cfg_q.pool_bytes   <= cfg_data_i;
        fsla_pkg::CfgIdent:  cfg_q.pool_ident   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  fsla_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .func_i       (fsla_pkg::func_e'(s_axis_tuser)),
    .slot_index_i (s_axis_tdata[9:0]),
    .owner_pool_i (s_axis_tdata[17:10]),
    .out_free_i   (out_free),
    .out_push_o   (out_push),
    .res_o        (ctrl_res),
    .mem_req_o    (mem_req),
    .rd_data_i    (rd_data)
  );

  fsla_link_ram u_link_ram (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  // Output register: load on push, drop on transfer
  assign out_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_push) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_push) begin
      out_q <= ctrl_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // Controller only pushes into a free output register
  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push |-> out_free)
    else $error("result pushed into occupied output register");

  // No request is taken in the cycle a result is pushed
  a_push_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push |-> !s_axis_tready)
    else $error("request taken while a result is pushed");

  // Empty answer grants nothing and reports an empty list
  a_empty_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == fsla_pkg::StEmpty) |->
      (out_q.granted_slot == '0 && out_q.byte_offset == '0 && out_q.pool_empty))
    else $error("empty result carries a grant");

  // Slot count stays within the link store
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.slot_total <= 11'(fsla_pkg::MaxSlots)))
    else $error("slot count beyond link store");

endmodule

// ----- hdl/fsla_link_ram.sv -----
module fsla_link_ram (
  input  logic               clk_i,
  input  fsla_pkg::mem_req_t req_i,
  output fsla_pkg::link_t    rd_data_o
);

  fsla_pkg::link_t link_mem_q [fsla_pkg::MaxSlots];
  fsla_pkg::link_t rd_data_q;

  // Write one link, read one link with registered data
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      link_mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= link_mem_q[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- hdl/fsla_ctrl.sv -----
module fsla_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  fsla_pkg::cfg_t                   cfg_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  fsla_pkg::func_e                  func_i,
  input  logic [fsla_pkg::SlotW-1:0]       slot_index_i,
  input  logic [7:0]                       owner_pool_i,
  input  logic                             out_free_i,
  output logic                             out_push_o,
  output fsla_pkg::res_t                   res_o,
  output fsla_pkg::mem_req_t               mem_req_o,
  input  fsla_pkg::link_t                  rd_data_i
);

  typedef enum logic [3:0] {
    SIdle  = 4'b0001,
    SAlloc = 4'b0010,
    SBuild = 4'b0100,
    SResp  = 4'b1000
  } state_e;

  state_e                      state_q, state_d;
  fsla_pkg::link_t             head_q, head_d;
  logic [10:0]                 count_q, count_d;
  logic [23:0]                 prod_q, prod_d;
  fsla_pkg::res_t              res_q, res_d;
  logic [fsla_pkg::SlotW-1:0]  k_q, k_d;
  logic [31:0]                 end_q, end_d;
  logic [24:0]                 first_end;
  logic                        too_small;
  logic                        last_slot;

  // First slot end against the pool size
  assign first_end = 25'(cfg_i.header_bytes) + 25'(cfg_i.slot_bytes);
  assign too_small = first_end > {1'b0, cfg_i.pool_bytes};

  // Current slot is the last one built when the next does not fit or the store is full
  assign last_slot = (k_q == fsla_pkg::SlotW'(fsla_pkg::MaxSlots - 1)) ||
                     (end_q > 32'(cfg_i.pool_bytes));

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    count_d    = count_q;
    prod_d     = prod_q;
    res_d      = res_q;
    k_d        = k_q;
    end_d      = end_q;
    mem_req_o  = '0;
    in_ready_o = 1'b0;
    out_push_o = 1'b0;
    res_o      = res_q;

    unique case (state_q)
      SIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          res_d.status       = fsla_pkg::StOk;
          res_d.granted_slot = '0;
          res_d.byte_offset  = '0;
          res_d.slot_total   = count_q;
          res_d.pool_empty   = (head_q == fsla_pkg::NoneLink);
          state_d            = SResp;
          unique case (func_i)
            fsla_pkg::FnAlloc: begin
              if (head_q == fsla_pkg::NoneLink) begin
                res_d.status = fsla_pkg::StEmpty;
              end else begin
                // Fetch the head's link and start the offset product
                mem_req_o.rd_en   = 1'b1;
                mem_req_o.rd_addr = head_q[fsla_pkg::SlotW-1:0];
                prod_d  = 24'(head_q[fsla_pkg::SlotW-1:0]) * 24'(cfg_i.slot_bytes);
                state_d = SAlloc;
              end
            end
            fsla_pkg::FnRelease: begin
              if (owner_pool_i != cfg_i.pool_ident) begin
                res_d.status = fsla_pkg::StWrong;
              end else begin
                // Push the slot on the head
                mem_req_o.wr_en   = 1'b1;
                mem_req_o.wr_addr = slot_index_i;
                mem_req_o.wr_data = head_q;
                head_d            = {1'b0, slot_index_i};
                res_d.pool_empty  = 1'b0;
              end
            end
            fsla_pkg::FnRebuild: begin
              if (too_small) begin
                res_d.status = fsla_pkg::StSmall;
              end else begin
                k_d     = '0;
                end_d   = 32'(cfg_i.header_bytes) + (32'(cfg_i.slot_bytes) << 1);
                state_d = SBuild;
              end
            end
            fsla_pkg::FnNop: begin
              res_d.status = fsla_pkg::StOk;
            end
            default: begin
              res_d.status = fsla_pkg::StOk;
            end
          endcase
        end
      end

      SAlloc: begin
        // Pop: the fetched link becomes the head
        head_d             = rd_data_i;
        res_d.status       = fsla_pkg::StOk;
        res_d.granted_slot = head_q[fsla_pkg::SlotW-1:0];
        res_d.byte_offset  = 24'(cfg_i.header_bytes) + prod_q;
        res_d.slot_total   = count_q;
        res_d.pool_empty   = (rd_data_i == fsla_pkg::NoneLink);
        res_o              = res_d;
        if (out_free_i) begin
          out_push_o = 1'b1;
          state_d    = SIdle;
        end else begin
          state_d = SResp;
        end
      end

      SBuild: begin
        // Link one slot per cycle
        mem_req_o.wr_en   = 1'b1;
        mem_req_o.wr_addr = k_q;
        mem_req_o.wr_data = last_slot ? fsla_pkg::NoneLink : ({1'b0, k_q} + 1'b1);
        end_d             = end_q + 32'(cfg_i.slot_bytes);
        k_d               = k_q + 1'b1;
        if (last_slot) begin
          head_d             = '0;
          count_d            = {1'b0, k_q} + 1'b1;
          res_d.status       = fsla_pkg::StOk;
          res_d.granted_slot = '0;
          res_d.byte_offset  = '0;
          res_d.slot_total   = count_d;
          res_d.pool_empty   = 1'b0;
          state_d            = SResp;
        end
      end

      SResp: begin
        if (out_free_i) begin
          out_push_o = 1'b1;
          state_d    = SIdle;
        end
      end

      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      head_q  <= fsla_pkg::NoneLink;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    res_q  <= res_d;
    k_q    <= k_d;
    end_q  <= end_d;
  end

endmodule
